@@ rtl/core/dnsle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS label encoder package
// Shared widths, constants and types of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnsle_pkg;

   localparam int MAX_LABEL   = 62;        // longest label kept, 1..63
   localparam int LEN_W       = 6;         // width of a label length
   localparam int BYTE_W      = 8;
   localparam int RSP_DEPTH   = 4;         // entries of the result queue
   localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;

   // One finished label, handed from the front to the back.
   typedef struct packed {
      logic [LEN_W-1:0] count;
      logic             ovf;
      logic             term;
      logic             bank;
   } cmd_type;

   // The back gives a label bank back to the front.
   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
      logic              ovf;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LEN,
      BK_DATA,
      BK_TERM
   } bk_state_type;

endpackage

@@ rtl/core/dns_name_label_encoder.sv @@
`timescale 1ns / 1ps
// A finished label passes the command queue, the back and its read stage in order.
// Throughput: one character per cycle in; results leave at one per cycle while
// the receiver pops, with an idle state per label in the back. Characters stall
// only while both label banks of the store are held by labels still being read out.
// Reset clears the states, pointers and counts; the label store holds no reset value.
// ----------------------------------------------------------------------------
// DNS name label encoder
// Converts a dotted name, one character per transfer, into DNS wire labels.
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
   parameter int MaxLabel = dnsle_pkg::MAX_LABEL
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [dnsle_pkg::BYTE_W-1:0]  req_ch,
   input  logic                          req_end_of_name,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [dnsle_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_last,
   output logic                          rsp_overflow
);

   localparam int IdxW     = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;
   localparam int RamDepth = 2 * (2 ** IdxW);

   logic                         ram_wr_en, ram_rd_en;
   logic [IdxW:0]                ram_wr_addr, ram_rd_addr;
   logic [dnsle_pkg::BYTE_W-1:0] ram_wr_data, ram_rd_data;
   logic                         cmd_push, cmd_full, cmd_pop, cmd_empty;
   dnsle_pkg::cmd_type           cmd_in_q, cmd_head;
   dnsle_pkg::rel_type           release_bank;

   dnsle_front #(
      .MaxLabel(MaxLabel)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_ch         (req_ch),
      .req_end_of_name(req_end_of_name),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .cmd_push       (cmd_push),
      .cmd            (cmd_in_q),
      .cmd_full       (cmd_full),
      .release_bank   (release_bank)
   );

   dnsle_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(cmd_in_q),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .head    (cmd_head),
      .empty   (cmd_empty)
   );

   dnsle_ram #(
      .Width(dnsle_pkg::BYTE_W),
      .Depth(RamDepth)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   dnsle_back #(
      .MaxLabel(MaxLabel)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_head    (cmd_head),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .release_bank(release_bank),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last),
      .rsp_overflow(rsp_overflow)
   );

endmodule

@@ rtl/core/dnsle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dnsle_ram #(
   parameter int Width = 8,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/dnsle_cmdq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label command queue
// Two-entry queue of finished labels between the front and the back.
// ----------------------------------------------------------------------------
module dnsle_cmdq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dnsle_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output dnsle_pkg::cmd_type head,
   output logic              empty
);

   dnsle_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/dnsle_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label encoder front
// Accepts name characters, fills the current label bank and hands finished
// labels to the command queue.
// ----------------------------------------------------------------------------
module dnsle_front #(
   parameter int MaxLabel = dnsle_pkg::MAX_LABEL,
   localparam int IdxW    = (MaxLabel > 1) ? $clog2(MaxLabel) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [dnsle_pkg::BYTE_W-1:0]  req_ch,
   input  logic                          req_end_of_name,
   output logic                          ram_wr_en,
   output logic [IdxW:0]                 ram_wr_addr,
   output logic [dnsle_pkg::BYTE_W-1:0]  ram_wr_data,
   output logic                          cmd_push,
   output dnsle_pkg::cmd_type            cmd,
   input  logic                          cmd_full,
   input  dnsle_pkg::rel_type            release_bank
);

   logic                        bank_ff, bank_in;
   logic [dnsle_pkg::LEN_W-1:0] count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic [1:0]                  busy_ff, busy_in;
   logic                        accept, is_delim, has_room;

   // A bank stays held from the transfer of its delimiter until the back has
   // read out its last character.
   assign req_full = busy_ff[bank_ff] | cmd_full;
   assign accept   = req_push & ~req_full;
   assign is_delim = req_end_of_name | (req_ch == dnsle_pkg::DOT_CHAR);
   assign has_room = (count_ff < dnsle_pkg::LEN_W'(MaxLabel));

   assign ram_wr_en   = accept & ~is_delim & has_room;
   assign ram_wr_addr = {bank_ff, count_ff[IdxW-1:0]};
   assign ram_wr_data = req_ch;

   assign cmd_push   = accept & is_delim;
   assign cmd.count  = count_ff;
   assign cmd.ovf    = ovf_ff;
   assign cmd.term   = req_end_of_name;
   assign cmd.bank   = bank_ff;

   always_comb begin
      bank_in  = bank_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      busy_in  = busy_ff;
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (accept) begin
         if (is_delim) begin
            busy_in[bank_ff] = 1'b1;
            bank_in          = ~bank_ff;
            count_in         = '0;
            ovf_in           = 1'b0;
         end else if (has_room) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         busy_ff  <= 2'b00;
      end else begin
         bank_ff  <= bank_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

@@ rtl/core/dnsle_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label encoder back
// Plays out each finished label as length byte, characters and, at the end of
// a name, terminator into a small result queue.
// ----------------------------------------------------------------------------
module dnsle_back #(
   parameter int MaxLabel = dnsle_pkg::MAX_LABEL,
   localparam int IdxW    = (MaxLabel > 1) ? $clog2(MaxLabel) : 1,
   localparam int PtrW    = $clog2(dnsle_pkg::RSP_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dnsle_pkg::cmd_type            cmd_head,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   output dnsle_pkg::rel_type            release_bank,
   output logic                          ram_rd_en,
   output logic [IdxW:0]                 ram_rd_addr,
   input  logic [dnsle_pkg::BYTE_W-1:0]  ram_rd_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [dnsle_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_last,
   output logic                          rsp_overflow
);

   dnsle_pkg::bk_state_type     state_ff, state_in;
   dnsle_pkg::cmd_type          cmd_ff, cmd_in;
   logic [dnsle_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic [dnsle_pkg::LEN_W-1:0] idx_next;
   logic                        idx_done, can_issue;

   logic                        issue;
   logic                        issue_is_data;
   logic [dnsle_pkg::BYTE_W-1:0] issue_byte;
   logic                        issue_last;

   logic                        s1_valid_ff;
   logic                        s1_is_data_ff;
   logic [dnsle_pkg::BYTE_W-1:0] s1_byte_ff;
   logic                        s1_last_ff;
   logic                        s1_ovf_ff;

   dnsle_pkg::rsp_type          rsp_mem_ff [dnsle_pkg::RSP_DEPTH];
   dnsle_pkg::rsp_type          rsp_head;
   logic [PtrW-1:0]             wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]               count_ff, count_in;
   logic                        do_pop;

   assign idx_next = idx_ff + 1'b1;
   assign idx_done = (idx_next == cmd_ff.count);

   // The pending read stage counts against the queue, so nothing issued is
   // ever left without a slot.
   assign can_issue = ((count_ff + {{PtrW{1'b0}}, s1_valid_ff})
                       < (PtrW + 1)'(dnsle_pkg::RSP_DEPTH));

   // Next state.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         dnsle_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_in   = cmd_head;
               state_in = dnsle_pkg::BK_LEN;
            end
         end
         dnsle_pkg::BK_LEN: begin
            if (can_issue) begin
               idx_in = '0;
               if (cmd_ff.count != '0) begin
                  state_in = dnsle_pkg::BK_DATA;
               end else if (cmd_ff.term) begin
                  state_in = dnsle_pkg::BK_TERM;
               end else begin
                  state_in = dnsle_pkg::BK_IDLE;
               end
            end
         end
         dnsle_pkg::BK_DATA: begin
            if (can_issue) begin
               idx_in = idx_next;
               if (idx_done) begin
                  state_in = cmd_ff.term ? dnsle_pkg::BK_TERM : dnsle_pkg::BK_IDLE;
               end
            end
         end
         dnsle_pkg::BK_TERM: begin
            if (can_issue) begin
               state_in = dnsle_pkg::BK_IDLE;
            end
         end
         default: state_in = dnsle_pkg::BK_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd_pop            = 1'b0;
      issue              = 1'b0;
      issue_is_data      = 1'b0;
      issue_byte         = '0;
      issue_last         = 1'b0;
      release_bank.valid = 1'b0;
      release_bank.bank  = cmd_ff.bank;
      unique case (state_ff)
         dnsle_pkg::BK_IDLE: begin
            cmd_pop = ~cmd_empty;
         end
         dnsle_pkg::BK_LEN: begin
            issue      = can_issue;
            issue_byte = dnsle_pkg::BYTE_W'(cmd_ff.count);
            issue_last = (cmd_ff.count == '0) & ~cmd_ff.term;
            // An empty label holds nothing to read, so its bank is free at once.
            release_bank.valid = can_issue & (cmd_ff.count == '0);
         end
         dnsle_pkg::BK_DATA: begin
            issue         = can_issue;
            issue_is_data = 1'b1;
            issue_last    = idx_done & ~cmd_ff.term;
            release_bank.valid = can_issue & idx_done;
         end
         dnsle_pkg::BK_TERM: begin
            issue      = can_issue;
            issue_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign ram_rd_en   = issue & issue_is_data;
   assign ram_rd_addr = {cmd_ff.bank, idx_ff[IdxW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dnsle_pkg::BK_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (issue) begin
         s1_is_data_ff <= issue_is_data;
         s1_byte_ff    <= issue_byte;
         s1_last_ff    <= issue_last;
         s1_ovf_ff     <= cmd_ff.ovf;
      end
   end

   // Result queue.
   assign do_pop    = rsp_pop & ~rsp_empty;
   assign rsp_empty = (count_ff == '0);
   assign count_in  = count_ff + {{PtrW{1'b0}}, s1_valid_ff} - {{PtrW{1'b0}}, do_pop};
   assign rsp_head  = rsp_mem_ff[rd_ptr_ff];

   assign rsp_out_byte = rsp_head.out_byte;
   assign rsp_last     = rsp_head.last;
   assign rsp_overflow = rsp_head.ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PtrW'(s1_valid_ff);
         rd_ptr_ff <= rd_ptr_ff + PtrW'(do_pop);
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_mem_ff[wr_ptr_ff].out_byte <= s1_is_data_ff ? ram_rd_data : s1_byte_ff;
         rsp_mem_ff[wr_ptr_ff].last     <= s1_last_ff;
         rsp_mem_ff[wr_ptr_ff].ovf      <= s1_ovf_ff;
      end
   end

endmodule

@@ verif/tb_dns_name_label_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS name label encoder testbench
// Feeds dotted names one character per transfer, predicts the wire-format
// label bytes with an independent encoder model and checks every result
// transfer in order, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_dns_name_label_encoder;

   localparam int ClockHigh     = 10;
   localparam int ClockLow      = 10;
   localparam int ResetCycles   = 11;
   localparam int CycleLimit    = 200000;
   localparam int DrainCycles   = 16;
   localparam int ItemsPerPhase = 50;
   localparam int NumPhases     = 4;

   typedef struct {
      logic [dnsle_pkg::BYTE_W-1:0] ch;
      logic                         is_end;
   } name_char_type;

   typedef struct {
      logic [dnsle_pkg::BYTE_W-1:0] out_byte;
      logic                         last;
      logic                         ovf;
   } wire_byte_type;

   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         req_push        = 1'b0;
   logic [dnsle_pkg::BYTE_W-1:0] req_ch          = '0;
   logic                         req_end_of_name = 1'b0;
   logic                         rsp_pop         = 1'b0;
   logic                         req_full;
   logic                         rsp_empty;
   logic [dnsle_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                         rsp_last;
   logic                         rsp_overflow;

   name_char_type     name_chars_pending[$];
   wire_byte_type     wire_bytes_expected[$];

   // Predictor state: the label being collected.
   logic [dnsle_pkg::BYTE_W-1:0] label_chars[dnsle_pkg::MAX_LABEL];
   int unsigned                  label_len     = 0;
   logic                         label_dropped = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int phase_items    = 0;
   int mismatches     = 0;
   int cycle_count    = 0;

   dns_name_label_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_ch          (req_ch),
      .req_end_of_name (req_end_of_name),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_overflow    (rsp_overflow)
   );

   always begin
      #ClockHigh clock = 1'b1;
      #ClockLow  clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic expect_byte(input logic [dnsle_pkg::BYTE_W-1:0] value, input logic last);
      wire_byte_type b;
      b.out_byte = value;
      b.last     = last;
      b.ovf      = label_dropped;
      wire_bytes_expected = {wire_bytes_expected, b};
   endtask

   // Length byte, then the kept characters, then the terminator if the name ends.
   task automatic emit_label(input logic with_terminator);
      expect_byte(dnsle_pkg::BYTE_W'(label_len), label_len == 0 && !with_terminator);
      for (int i = 0; i < label_len; i++)
         expect_byte(label_chars[i], i == label_len - 1 && !with_terminator);
      if (with_terminator)
         expect_byte('0, 1'b1);
      label_len     = 0;
      label_dropped = 1'b0;
   endtask

   task automatic encode_name_char(input name_char_type c);
      if (c.is_end) begin
         emit_label(1'b1);
      end else if (c.ch == dnsle_pkg::DOT_CHAR) begin
         emit_label(1'b0);
      end else if (label_len < dnsle_pkg::MAX_LABEL) begin
         label_chars[label_len] = c.ch;
         label_len++;
      end else begin
         label_dropped = 1'b1;
      end
   endtask

   task automatic push_name_char(input logic [dnsle_pkg::BYTE_W-1:0] ch, input logic is_end);
      name_char_type c;
      c.ch     = ch;
      c.is_end = is_end;
      name_chars_pending = {name_chars_pending, c};
      phase_items++;
   endtask

   function automatic logic [dnsle_pkg::BYTE_W-1:0] random_label_char();
      logic [dnsle_pkg::BYTE_W-1:0] v;
      v = dnsle_pkg::BYTE_W'($urandom_range(0, 255));
      while (v == dnsle_pkg::DOT_CHAR)
         v = dnsle_pkg::BYTE_W'($urandom_range(0, 255));
      return v;
   endfunction

   task automatic queue_label(input int len);
      repeat (len) push_name_char(random_label_char(), 1'b0);
   endtask

   // Mostly well-formed names with short labels; a few near or past the label
   // limit, some empty labels, and now and then a burst of raw noise.
   task automatic queue_random_name();
      int labels;
      int pick;
      int len;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6))
            push_name_char(dnsle_pkg::BYTE_W'($urandom_range(0, 255)),
                           $urandom_range(0, 3) == 0);
         return;
      end
      labels = $urandom_range(1, 4);
      if ($urandom_range(0, 19) == 0)
         push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
      for (int i = 0; i < labels; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            len = 0;
         else if (pick < 90)
            len = $urandom_range(1, 12);
         else if (pick < 95)
            len = $urandom_range(dnsle_pkg::MAX_LABEL - 6, dnsle_pkg::MAX_LABEL);
         else
            len = $urandom_range(dnsle_pkg::MAX_LABEL + 1, dnsle_pkg::MAX_LABEL + 8);
         if (i > 0)
            push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
         queue_label(len);
      end
      if ($urandom_range(0, 9) == 0)
         push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
      push_name_char(dnsle_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic queue_directed_names();
      // Empty name, then a lone dot giving an empty label before the end.
      push_name_char(8'h00, 1'b1);
      push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
      push_name_char(8'h41, 1'b1);
      // Doubled dot; the end transfer carries a dot that must be ignored.
      push_name_char(8'h61, 1'b0);
      push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
      push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
      push_name_char(8'h62, 1'b0);
      push_name_char(dnsle_pkg::DOT_CHAR, 1'b1);
      // Byte extremes and the neighbors of the dot code, with a trailing dot.
      push_name_char(8'h00, 1'b0);
      push_name_char(8'hFF, 1'b0);
      push_name_char(8'h2D, 1'b0);
      push_name_char(8'h2F, 1'b0);
      push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
      push_name_char(8'hFF, 1'b1);
      push_name_char(8'h7F, 1'b0);
      push_name_char(8'h80, 1'b0);
      push_name_char(8'h55, 1'b1);
      push_name_char(8'hAA, 1'b0);
      push_name_char(8'h00, 1'b1);
   endtask

   // Sender side: present the oldest pending character unless idling.
   always @(negedge clock) begin
      if (reset || name_chars_pending.size() == 0
          || $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
      end else begin
         req_push        <= 1'b1;
         req_ch          <= name_chars_pending[0].ch;
         req_end_of_name <= name_chars_pending[0].is_end;
      end
      rsp_pop <= !reset && $urandom_range(0, 99) >= recv_stall_pct;
   end

   // An accepted character updates the predicted wire bytes.
   always @(posedge clock) begin
      if (!reset && req_push && !req_full)
         encode_name_char(name_chars_pending.pop_front());
   end

   always @(posedge clock) begin
      wire_byte_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (wire_bytes_expected.size() == 0) begin
            report_mismatch("unexpected result byte", rsp_out_byte, 0);
         end else begin
            want = wire_bytes_expected.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
            if (rsp_overflow !== want.ovf)
               report_mismatch("overflow", rsp_overflow, want.ovf);
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      int send_pcts[NumPhases];
      int recv_pcts[NumPhases];
      send_pcts = '{0, 69, 0, 27};
      recv_pcts = '{0, 0, 69, 27};
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NumPhases; p++) begin
         @(posedge clock);
         send_idle_pct  = send_pcts[p];
         recv_stall_pct = recv_pcts[p];
         phase_items    = 0;
         if (p == 0) begin
            queue_directed_names();
            // A label exactly at the limit, then one that spills past it.
            queue_label(dnsle_pkg::MAX_LABEL);
            push_name_char(dnsle_pkg::DOT_CHAR, 1'b0);
            queue_label(dnsle_pkg::MAX_LABEL + 3);
            push_name_char(8'h00, 1'b1);
         end
         while (phase_items < ItemsPerPhase)
            queue_random_name();
         while (name_chars_pending.size() != 0 || wire_bytes_expected.size() != 0)
            @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && wire_bytes_expected.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
